/* hdl/stsch_pkg.sv */
// ----------------------------------------------------------------------------
// stsch_pkg: shared types and helpers for the stride scheduler
// Holds the controller state type, the command and status bundles between
// the controller and the datapath, fixed field widths and the pass compare.
// ----------------------------------------------------------------------------
package stsch_pkg;

    // Fixed widths of the item fields.
    localparam int PASS_W = 32;
    localparam int TIX_W  = 16;
    localparam int MASK_W = 8;
    localparam int PORT_W = 3;
    localparam int VIS_W  = 4;

    // Operation codes of an input beat.
    localparam logic OP_PULL = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_DIV,
        ST_APPLY,
        ST_WALK,
        ST_INS,
        ST_FIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic set_apply;
        logic walk;
        logic ins;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_set;
        logic need_div;
        logic list_empty;
        logic div_done;
        logic walk_last;
        logic ins_last;
        logic out_free;
    } t_sts;

    // Wrap-safe compare: a is later than b when a - b lies in 1 .. 2^31-1.
    function automatic logic pass_later(input logic [PASS_W-1:0] a,
                                        input logic [PASS_W-1:0] b);
        logic [PASS_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[PASS_W-1];
    endfunction

endpackage

/* hdl/stsch_div.sv */
// ----------------------------------------------------------------------------
// stsch_div: stride divider
// Restoring divider that computes the constant stride numerator divided by
// a ticket count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stsch_div
    import stsch_pkg::*;
#(
    parameter int DIVIDEND = 65536,
    parameter int SW       = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TIX_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SW-1:0]    o_quot
);

    localparam int CNT_W = $clog2(SW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TIX_W-1:0] r_rem;
    logic [SW-1:0]    r_q;

    logic [TIX_W:0]   trial;
    logic             q_bit;
    logic [TIX_W-1:0] n_rem;

    // One restoring step: shift in the next numerator bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_q[SW-1]};
        if (trial >= {1'b0, i_divisor}) begin
            q_bit = 1'b1;
            n_rem = TIX_W'(trial - {1'b0, i_divisor});
        end else begin
            q_bit = 1'b0;
            n_rem = trial[TIX_W-1:0];
        end
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= SW'(DIVIDEND);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[SW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hdl/stsch_ctrl.sv */
// ----------------------------------------------------------------------------
// stsch_ctrl: stride scheduler controller
// Sequences one beat at a time through decode, divide, ticket apply, walk,
// reinsert and result hand-off.
// ----------------------------------------------------------------------------
module stsch_ctrl
    import stsch_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DEC;
                end
            end
            ST_DEC: begin
                if (i_sts.is_set) begin
                    if (i_sts.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end else begin
                        n_state = ST_APPLY;
                    end
                end else if (i_sts.list_empty) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_cmd.set_apply = 1'b1;
                n_state         = ST_FIN;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.ins = 1'b1;
                if (i_sts.ins_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/stsch_dp.sv */
// ----------------------------------------------------------------------------
// stsch_dp: stride scheduler datapath
// Sorted row of client cells (id, pass, stride), ticket store, visit buffer,
// stride divider and the result register.
// ----------------------------------------------------------------------------
module stsch_dp
    import stsch_pkg::*;
#(
    parameter int NUM_CLIENTS  = 8,
    parameter int TICKET_LIMIT = 32768,
    parameter int STRIDE_ONE   = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_op,
    input  logic [MASK_W-1:0] i_ready_mask,
    input  logic [PORT_W-1:0] i_port,
    input  logic [TIX_W-1:0]  i_ticket_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_granted,
    output logic [PORT_W-1:0] o_grant_port,
    output logic [VIS_W-1:0]  o_visited
);

    localparam int N  = NUM_CLIENTS;
    localparam int CW = $clog2(N);
    localparam int KW = $clog2(N + 1);
    localparam int SW = $clog2(STRIDE_ONE + 1);

    // Latched beat.
    logic             r_op;
    logic [N-1:0]     r_mask;
    logic [CW-1:0]    r_pidx;
    logic             r_pok;
    logic [TIX_W-1:0] r_tix;

    // Client state.
    logic [TIX_W-1:0]  r_tk [N];
    logic [CW-1:0]     r_id [N];
    logic [PASS_W-1:0] r_pass [N];
    logic [SW-1:0]     r_strd [N];
    logic [KW-1:0]     r_cnt;

    // Visit buffer and pull bookkeeping.
    logic [CW-1:0]     r_sid [N];
    logic [PASS_W-1:0] r_spass [N];
    logic [SW-1:0]     r_sstrd [N];
    logic [KW-1:0]     r_k;
    logic [KW-1:0]     r_i;
    logic              r_found;
    logic [CW-1:0]     r_gp;

    // Result register.
    logic              r_ov;
    logic              r_og;
    logic [PORT_W-1:0] r_ogp;
    logic [VIS_W-1:0]  r_ovis;

    logic [N-1:0]      mask_n;
    logic [4:0]        port5;
    logic [TIX_W-1:0]  tix_sat;
    logic [TIX_W-1:0]  old_tix;
    logic              div_done;
    logic [SW-1:0]     quot;
    logic              head_ready;
    logic [PASS_W-1:0] head_pass_nxt;
    logic              do_add;
    logic              do_rm;
    logic              do_upd;
    logic              do_ins;
    logic [PASS_W-1:0] ins_key;
    logic [CW-1:0]     ins_id;
    logic [SW-1:0]     ins_strd;
    logic [CW-1:0]     ins_pos;
    logic [CW-1:0]     rm_pos;
    logic [4:0]        gp5;

    // Input decode: mask widened to the client count, port range, saturation.
    always_comb begin
        for (int j = 0; j < N; j++) begin
            mask_n[j] = (j < MASK_W) && i_ready_mask[j % MASK_W];
        end
        port5   = 5'(i_port);
        tix_sat = (i_ticket_count > TIX_W'(TICKET_LIMIT)) ? TIX_W'(TICKET_LIMIT)
                                                          : i_ticket_count;
    end

    stsch_div #(
        .DIVIDEND (STRIDE_ONE),
        .SW       (SW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (r_tix),
        .o_done    (div_done),
        .o_quot    (quot)
    );

    // Ticket change decode.
    always_comb begin
        old_tix = r_tk[r_pidx];
        do_add  = i_cmd.set_apply && r_pok && (r_tix != '0) && (old_tix == '0);
        do_rm   = i_cmd.set_apply && r_pok && (r_tix == '0) && (old_tix != '0);
        do_upd  = i_cmd.set_apply && r_pok && (r_tix != '0) && (old_tix != '0);
        do_ins  = i_cmd.ins || do_add;
    end

    // Head of the list during a walk.
    always_comb begin
        head_ready    = r_mask[r_id[0]];
        head_pass_nxt = r_pass[0] + PASS_W'(r_strd[0]);
    end

    // Insertion source and position: before the first entry not earlier than the key.
    always_comb begin
        if (i_cmd.ins) begin
            ins_key  = r_spass[r_i[CW-1:0]];
            ins_id   = r_sid[r_i[CW-1:0]];
            ins_strd = r_sstrd[r_i[CW-1:0]];
        end else begin
            ins_key  = (r_cnt != '0) ? (r_pass[0] + PASS_W'(quot)) : '0;
            ins_id   = r_pidx;
            ins_strd = quot;
        end
        ins_pos = CW'(r_cnt);
        for (int j = N - 1; j >= 0; j--) begin
            if ((KW'(j) < r_cnt) && !pass_later(ins_key, r_pass[j])) begin
                ins_pos = CW'(j);
            end
        end
    end

    // Position of the client that leaves the list.
    always_comb begin
        rm_pos = '0;
        for (int j = N - 1; j >= 0; j--) begin
            if ((KW'(j) < r_cnt) && (r_id[j] == r_pidx)) begin
                rm_pos = CW'(j);
            end
        end
    end

    // Latch the beat when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_mask <= mask_n;
            r_pidx <= port5[CW-1:0];
            r_pok  <= port5 < 5'(N);
            r_tix  <= tix_sat;
        end
    end

    // Ticket store and list length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int j = 0; j < N; j++) begin
                r_tk[j] <= '0;
            end
        end else begin
            if (i_cmd.set_apply && r_pok) begin
                r_tk[r_pidx] <= r_tix;
            end
            if (i_cmd.walk || do_rm) begin
                r_cnt <= r_cnt - KW'(1);
            end else if (do_ins) begin
                r_cnt <= r_cnt + KW'(1);
            end
        end
    end

    // Cell row: pop on walk, shift out on removal, shift in on insertion, new stride on update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            for (int j = 0; j < N - 1; j++) begin
                r_id[j]   <= r_id[j+1];
                r_pass[j] <= r_pass[j+1];
                r_strd[j] <= r_strd[j+1];
            end
        end else if (do_rm) begin
            for (int j = 0; j < N - 1; j++) begin
                if (CW'(j) >= rm_pos) begin
                    r_id[j]   <= r_id[j+1];
                    r_pass[j] <= r_pass[j+1];
                    r_strd[j] <= r_strd[j+1];
                end
            end
        end else if (do_ins) begin
            for (int j = 0; j < N; j++) begin
                if (CW'(j) == ins_pos) begin
                    r_id[j]   <= ins_id;
                    r_pass[j] <= ins_key;
                    r_strd[j] <= ins_strd;
                end else if ((j > 0) && (CW'(j) > ins_pos)) begin
                    r_id[j]   <= r_id[(j + N - 1) % N];
                    r_pass[j] <= r_pass[(j + N - 1) % N];
                    r_strd[j] <= r_strd[(j + N - 1) % N];
                end
            end
        end else if (do_upd) begin
            for (int j = 0; j < N; j++) begin
                if ((KW'(j) < r_cnt) && (r_id[j] == r_pidx)) begin
                    r_strd[j] <= quot;
                end
            end
        end
    end

    // Visit buffer: visited clients with their advanced pass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_sid[r_k[CW-1:0]]   <= r_id[0];
            r_spass[r_k[CW-1:0]] <= head_pass_nxt;
            r_sstrd[r_k[CW-1:0]] <= r_strd[0];
        end
    end

    // Pull bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_i     <= '0;
            r_found <= 1'b0;
            r_gp    <= '0;
        end else if (i_cmd.load) begin
            r_k     <= '0;
            r_i     <= '0;
            r_found <= 1'b0;
            r_gp    <= '0;
        end else begin
            if (i_cmd.walk) begin
                r_k <= r_k + KW'(1);
                if (head_ready) begin
                    r_found <= 1'b1;
                    r_gp    <= r_id[0];
                end
            end
            if (i_cmd.ins) begin
                r_i <= r_i + KW'(1);
            end
        end
    end

    // Result register; a set beat reports all zero.
    assign gp5 = 5'(r_gp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_og   <= (r_op == OP_PULL) && r_found;
            r_ogp  <= (r_op == OP_PULL) ? gp5[PORT_W-1:0] : '0;
            r_ovis <= (r_op == OP_PULL) ? VIS_W'(r_k) : '0;
        end
    end

    assign o_valid      = r_ov;
    assign o_granted    = r_og;
    assign o_grant_port = r_ogp;
    assign o_visited    = r_ovis;

    // Status to the controller.
    always_comb begin
        o_sts.is_set     = (r_op == OP_SET);
        o_sts.need_div   = r_pok && (r_tix != '0);
        o_sts.list_empty = (r_cnt == '0);
        o_sts.div_done   = div_done;
        o_sts.walk_last  = head_ready || (r_cnt == KW'(1));
        o_sts.ins_last   = (r_i + KW'(1)) == r_k;
        o_sts.out_free   = !r_ov || i_ready;
    end

endmodule

/* hdl/stride_scheduler.sv */
// ----------------------------------------------------------------------------
// stride_scheduler: proportional-share stride arbiter
// Takes one beat at a time and returns exactly one result beat per input
// beat. A pull pops visited clients from the head of the sorted cell row,
// advancing the pass of each, then reinserts them one by one into the row.
// A ticket change to a nonzero count first runs the divider, which produces
// one stride bit per cycle; other ticket changes skip the divider. The
// result register lets the next beat be accepted while the previous result
// still waits to be taken.
// ----------------------------------------------------------------------------
module stride_scheduler
    import stsch_pkg::*;
#(
    parameter int NUM_CLIENTS  = 8,
    parameter int TICKET_LIMIT = 32768,
    parameter int STRIDE_ONE   = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [MASK_W-1:0] i_ready_mask,
    input  logic [PORT_W-1:0] i_port,
    input  logic [TIX_W-1:0]  i_ticket_count,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_granted,
    output logic [PORT_W-1:0] o_grant_port,
    output logic [VIS_W-1:0]  o_visited
);

    t_cmd cmd;
    t_sts sts;

    stsch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_sts      (sts),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    stsch_dp #(
        .NUM_CLIENTS  (NUM_CLIENTS),
        .TICKET_LIMIT (TICKET_LIMIT),
        .STRIDE_ONE   (STRIDE_ONE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_op           (i_op),
        .i_ready_mask   (i_ready_mask),
        .i_port         (i_port),
        .i_ticket_count (i_ticket_count),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_granted      (o_granted),
        .o_grant_port   (o_grant_port),
        .o_visited      (o_visited)
    );

    // Only one datapath operation runs in any cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.div_start, cmd.set_apply, cmd.walk, cmd.ins, cmd.out_load}))
        else $error("more than one datapath command at once");

    // A beat is taken only while no earlier beat is still in work.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("beat accepted while another is in work");

    // A result without a grant names no client.
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_grant_port == '0))
        else $error("grant port set without a grant");

    // A result is loaded only when the result register can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("result loaded over a waiting result");

endmodule
